// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

// A condition that implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

// ===== hw/rtl/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Constants, types and round functions shared by the MD5 digest modules.
// ----------------------------------------------------------------------------
`default_nettype none

package md5_pkg;

  typedef logic [31:0] md5_word_t;
  typedef logic [3:0][31:0] md5_chain_t;

  typedef struct packed {
    logic start;
    logic restart;
  } md5_ctrl_t;

  localparam md5_word_t INIT_A = 32'h67452301;
  localparam md5_word_t INIT_B = 32'hefcdab89;
  localparam md5_word_t INIT_C = 32'h98badcfe;
  localparam md5_word_t INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LAST_POS = 6'd63;
  localparam logic [5:0] PRE_LEN_POS = 6'd55;
  localparam logic [6:0] LAST_STEP = 7'd65;

  localparam md5_word_t ROUND_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  function automatic logic [3:0] md5_word_index(input logic [5:0] idx);
    logic [3:0] n;
    n = idx[3:0];
    case (idx[5:4])
      2'd0:    return n;
      2'd1:    return 4'(n * 4'd5 + 4'd1);
      2'd2:    return 4'(n * 4'd3 + 4'd5);
      default: return 4'(n * 4'd7);
    endcase
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] idx);
    logic [3:0] sel;
    sel = {idx[5:4], idx[1:0]};
    case (sel)
      4'd0:    return 5'd7;
      4'd1:    return 5'd12;
      4'd2:    return 5'd17;
      4'd3:    return 5'd22;
      4'd4:    return 5'd5;
      4'd5:    return 5'd9;
      4'd6:    return 5'd14;
      4'd7:    return 5'd20;
      4'd8:    return 5'd4;
      4'd9:    return 5'd11;
      4'd10:   return 5'd16;
      4'd11:   return 5'd23;
      4'd12:   return 5'd6;
      4'd13:   return 5'd10;
      4'd14:   return 5'd15;
      default: return 5'd21;
    endcase
  endfunction

  function automatic md5_word_t md5_mix(input logic [1:0] rnd, input md5_word_t b,
                                        input md5_word_t c, input md5_word_t d);
    case (rnd)
      2'd0:    return (b & c) | (~b & d);
      2'd1:    return (b & d) | (c & ~d);
      2'd2:    return b ^ c ^ d;
      default: return c ^ (b | ~d);
    endcase
  endfunction

  function automatic md5_word_t md5_rotl(input md5_word_t v, input logic [4:0] s);
    logic [63:0] wide;
    wide = {v, v} << s;
    return wide[63:32];
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/md5_wbuf.sv =====
// ----------------------------------------------------------------------------
// MD5 block buffer
// Sixteen-word message block memory with byte-lane writes and one
// registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_wbuf
  import md5_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      wr_en,
  input  wire logic [3:0] wr_addr,
  input  wire logic [1:0] wr_lane,
  input  wire logic [7:0] wr_byte,
  input  wire logic [3:0] rd_addr,
  output md5_word_t      rd_data
);

  md5_word_t mem [16];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr][{wr_lane, 3'b000} +: 8] <= wr_byte;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5_core.sv =====
// ----------------------------------------------------------------------------
// MD5 compression core
// Runs the 64 steps of one block, one step per cycle, fetching message
// words from the block buffer, and holds the chaining value.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_core
  import md5_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  md5_ctrl_t       ctrl,
  output logic [3:0]      rd_addr,
  input  md5_word_t       rd_data,
  output logic            done,
  output md5_chain_t      chain
);

  typedef enum logic [1:0] {
    C_IDLE,
    C_RUN,
    C_FIN
  } core_state_t;

  core_state_t state;
  logic [6:0]  step;
  md5_word_t   a, b, c, d;
  md5_word_t   kw;
  logic [5:0]  kidx;
  logic [5:0]  ridx;
  md5_word_t   t;

  assign rd_addr = md5_word_index(step[5:0]);
  assign kidx = 6'(step - 7'd1);
  assign ridx = 6'(step - 7'd2);
  assign t = a + md5_mix(ridx[5:4], b, c, d) + kw;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      step <= '0;
      done <= 1'b0;
      chain <= {INIT_D, INIT_C, INIT_B, INIT_A};
    end else begin
      done <= 1'b0;
      unique case (state)
        C_IDLE: begin
          step <= '0;
          if (ctrl.start) begin
            a <= chain[0];
            b <= chain[1];
            c <= chain[2];
            d <= chain[3];
            state <= C_RUN;
          end
        end
        C_RUN: begin
          kw <= rd_data + ROUND_CONST[kidx];
          if (step >= 7'd2) begin
            a <= d;
            d <= c;
            c <= b;
            b <= b + md5_rotl(t, md5_rot(ridx));
          end
          step <= step + 7'd1;
          if (step == LAST_STEP) begin
            state <= C_FIN;
          end
        end
        C_FIN: begin
          chain[0] <= chain[0] + a;
          chain[1] <= chain[1] + b;
          chain[2] <= chain[2] + c;
          chain[3] <= chain[3] + d;
          done <= 1'b1;
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
      if (ctrl.restart) begin
        chain <= {INIT_D, INIT_C, INIT_B, INIT_A};
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5_message_digest_top.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-stream MD5 hash engine with a streaming input and a digest output.
// ----------------------------------------------------------------------------
// The input channel takes one item per handshake: tuser selects absorb (0)
// or finish (1), and tdata carries the message byte for an absorb item.
// An absorb item is written into the block buffer; the item
// that completes a 64-byte block is followed by a compression pass
// through the one-step-per-cycle round loop of the core.
// A finish item writes the padding and the bit count one byte per cycle
// (9 to 72 bytes), runs one or two compression passes, and then loads
// the 128-bit digest into the output register, word 0 in the low bits,
// when the output register is free.
// The chaining value and count then restart for a new message.
// The input is ready only while no block work is under way. A digest
// that the receiver has not yet taken does not block further absorb
// items; the next digest waits until the output register is free.
// Reset is synchronous and returns the block to an empty message.
// ----------------------------------------------------------------------------
`default_nettype none

module md5_message_digest_top
  import md5_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // [7:0] data_byte
  input  wire logic         s_tuser,   // [0] action
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [127:0]      m_tdata    // [31:0] digest_word0, [63:32] digest_word1,
                                       // [95:64] digest_word2, [127:96] digest_word3
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PAD,
    S_COMP,
    S_EMIT
  } top_state_t;

  top_state_t  state;
  top_state_t  ret_state;
  logic [60:0] byte_count;
  logic [60:0] len_bytes;
  logic [63:0] len_bits;
  logic [5:0]  pad_pos;
  logic        marked;
  logic        len_phase;
  md5_ctrl_t   ctrl;
  logic        accept;
  logic        wr_en;
  logic [5:0]  wr_pos;
  logic [7:0]  wr_byte;
  logic [7:0]  pad_byte;
  logic [3:0]  rd_addr;
  md5_word_t   rd_data;
  logic        done;
  md5_chain_t  chain;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign len_bits = {len_bytes, 3'b000};

  always_comb begin
    if (!marked) begin
      pad_byte = PAD_MARK;
    end else if (len_phase) begin
      pad_byte = len_bits[{pad_pos[2:0], 3'b000} +: 8];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign wr_en = (accept && !s_tuser) || (state == S_PAD);
  assign wr_pos = (state == S_PAD) ? pad_pos : byte_count[5:0];
  assign wr_byte = (state == S_PAD) ? pad_byte : s_tdata;

  md5_wbuf u_wbuf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_pos[5:2]),
    .wr_lane (wr_pos[1:0]),
    .wr_byte (wr_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  md5_core u_core (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .done    (done),
    .chain   (chain)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret_state <= S_IDLE;
      byte_count <= '0;
      m_tvalid <= 1'b0;
      ctrl <= '0;
      marked <= 1'b0;
      len_phase <= 1'b0;
    end else begin
      ctrl <= '0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (!s_tuser) begin
              byte_count <= byte_count + 61'd1;
              if (byte_count[5:0] == LAST_POS) begin
                ctrl.start <= 1'b1;
                ret_state <= S_IDLE;
                state <= S_COMP;
              end
            end else begin
              len_bytes <= byte_count;
              byte_count <= '0;
              pad_pos <= byte_count[5:0];
              marked <= 1'b0;
              len_phase <= 1'b0;
              state <= S_PAD;
            end
          end
        end
        S_PAD: begin
          marked <= 1'b1;
          pad_pos <= pad_pos + 6'd1;
          if (pad_pos == PRE_LEN_POS && !len_phase) begin
            len_phase <= 1'b1;
          end
          if (pad_pos == LAST_POS) begin
            ctrl.start <= 1'b1;
            ret_state <= len_phase ? S_EMIT : S_PAD;
            state <= S_COMP;
          end
        end
        S_COMP: begin
          if (done) begin
            state <= ret_state;
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tdata <= chain;
            m_tvalid <= 1'b1;
            ctrl.restart <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/md5_md_chk.sv =====
// ----------------------------------------------------------------------------
// MD5 port checker
// Checks the behavior of the digest block as seen on its ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module md5_md_chk (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_tvalid,
  input wire logic         s_tready,
  input wire logic [7:0]   s_tdata,
  input wire logic         s_tuser,
  input wire logic         m_tvalid,
  input wire logic         m_tready,
  input wire logic [127:0] m_tdata
);

  logic fin_accept;
  logic out_stall;
  logic data_seen;

  assign fin_accept = s_tvalid && s_tready && s_tuser;
  assign out_stall = m_tvalid && !m_tready;
  assign data_seen = (s_tdata == s_tdata) && (m_tdata == m_tdata);

  `ASSERT_NEXT(a_hold_valid, clk, rst, out_stall, m_tvalid)
  `ASSERT_NEXT(a_hold_data, clk, rst, out_stall, $stable(m_tdata))
  `ASSERT_NEXT(a_finish_busy, clk, rst, fin_accept, !s_tready)
  `ASSERT_ALWAYS(a_digest_after_work, clk, rst,
                 !$rose(m_tvalid) || ($past(!s_tready) && data_seen))

endmodule

bind md5_message_digest_top md5_md_chk u_md5_md_chk (.*);

`default_nettype wire
